/* hdl/gbpy_pkg.sv */
// Shared types, constants and lookup functions for the GB2312 pinyin initial extractor.
// Used by the interfaces' neighbors, the front end, the job queue and the back end.
// Depends on nothing.
`default_nettype none

package gbpy_pkg;

  // Default depth of the queue between front end and back end.
  localparam int GBPY_QUEUE_DEPTH = 2;

  localparam logic [7:0] LEAD_MIN  = 8'h80;
  localparam logic [7:0] PAIR_MIN  = 8'hA1;
  localparam logic [7:0] PAIR_BIAS = 8'hA0;

  localparam logic [13:0] CODE_RANGE_LO  = 14'd1601;
  localparam logic [13:0] CODE_RANGE_END = 14'd5590;
  localparam logic [13:0] CODE_ROM_LO    = 14'd5601;
  localparam logic [13:0] CODE_ROM_HI    = 14'd8794;
  localparam logic [13:0] ROW_WEIGHT     = 14'd100;

  localparam logic [6:0]  ROM_ROW_BASE = 7'd56;
  localparam logic [11:0] ROM_ROW_SPAN = 12'd94;

  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  // How a completed character is looked up.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RANGE,
    KIND_ROM
  } kind_t;

  // One job handed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [13:0] code;
    logic [11:0] rom_idx;
    logic        last;
  } job_t;

  localparam int RANGE_COUNT = 23;

  localparam logic [13:0] RANGE_TOP [RANGE_COUNT] = '{
    14'd1637, 14'd1833, 14'd2078, 14'd2274, 14'd2302, 14'd2433, 14'd2594, 14'd2787,
    14'd3106, 14'd3212, 14'd3472, 14'd3635, 14'd3722, 14'd3730, 14'd3858, 14'd4027,
    14'd4086, 14'd4390, 14'd4558, 14'd4684, 14'd4925, 14'd5249, 14'd5590
  };

  // A B C D E F G H J K L M N O P Q R S T W X Y Z
  localparam logic [6:0] RANGE_LETTER [RANGE_COUNT] = '{
    7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72,
    7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81,
    7'd82, 7'd83, 7'd84, 7'd87, 7'd88, 7'd89, 7'd90
  };

  // Initials of the second-level characters, first character in the top byte.
  localparam ROM_TEXT = {
    "cjwgnspgcenegypbtwxzdxykygtpjnmjqmbsgzscyjsyyfpggbzgydywjkgaljswkbjqhyjwpdzlsgmr",
    "ybywwccgznkydgttngjeyekzydcjnmcylqlypyqbqrpzslwbdgkjfyxjwcltbncxjjjjcxdtqsqzycdxxhgckbphffss",
    "pybgmxjbbyglbhlssmzmpjhsojnghdzcdklgjhsgqzhxqgkezzwymcscjnyetxadzpmdssmzjjqjyzcjjfwqjbdzbjgd",
    "nzcbwhgxhqkmwfbpbqdtjjzkqhylcgxfptyjyyzpsjlfchmqshgmmxsxjpkdcmbbqbefsjwhwwgckpylqbgldlcctnma",
    "eddksjngkcsgxlhzaybdbtsdkdylhgymylcxpycjndqjwxqxfyyfjlejbzrwccqhqcsbzkymgplbmcrqcflnymyqmsqt",
    "rbcjthztqfrxchxmcjcjlxqgjmshzkbswxemdlckfsydsglycjjssjnqbjctyhbftdcyjdgwyghqfrxwckqkxebpdjpx",
    "jqsrmebwgjlbjslyysmdxlclqkxlhtjrjjmbjhxhwywcbhtrxxglhjhfbmgykldyxzpplggpmtcbbajjzyljtyanjgbj",
    "flqgdzyqcaxbkclecjsznslyzhlxlzcghbxzhznytdsbcjkdlzayffydlabbgqszkggldndnyskjshdlxxbcghxyggdj",
    "mmzngmmccgwzszxsjbznmlzdthcqydbdllscddnlkjyhjsycjlkohqasdhnhcsgaehdaashtcplcpqybsdmpjlpcjaql",
    "cdhjjasprchngjnlhlyyqyhwzpnccgwwmzffjqqqqxxaclbhkdjxdgmmydjxzllsygxgkjrywzwyclzmcsjzldbndcfc",
    "xyhlschycjqppqagmnyxpfrkssbjlyxyjjglnscmhcwwmnzjjlhmhchsyppttxrycsxbyhcsmxjsxnbwgpxxtaybgajc",
    "xlypdccwqocwkccsbnhcpdyznbcyytyckskybsqkkytqqxfcwchcwkelcqbsqyjqcclmthsywhmktlkjlychwheqjhtj",
    "hppqpqscfymmcmgbmhglgsllysdllljpchmjhwljcyhzjxhdxjlhxrswlwzjcbxmhzqxsdzpmgfcsglsdymjshxpjxom",
    "yqknmyblrthbcftpmgyxlchlhlzylxgsssscclsldclepbhshxyyfhbmgdfycnjqwlqhjjcywjztejjdhfblqxtqkwhd",
    "chqxagtlxljxmsljhdzkzjecxjcjnmbbjcsfywkbjzghysdcpqyrsljpclpwxsdwejbjcbcnaytmgmbapclyqbclzxcb",
    "nmsggfnzjjbzsfqyndxhpcqkzczwalsbccjxpozgwkybsgxfcfcdkhjbstlqfsgdslqwzkxtmhsbgzhjcrglyjbpmljs",
    "xlcjqqhzmjczydjwbmjklddpmjegxyhylxhlqyqhkycwcjmyhxnatjhyccxzpcqlbzwwwtwbqcmlbmynjcccxbbsnzzl",
    "jpljxyztzlgcldcklyrzzgqtgjhhgjljaxfgfjzslcfdqzlclgjdjcsnclljpjqdcclcjxmyzftsxgcgsbrzxjqqcczh",
    "gyjdjqqlzxjyldlbcyamcstylbdjbyregklzdzhldszchznwczcllwjqjjjkdgjcolbbzppglghtgzcygezmycnqcycy",
    "hbhgxkamtxyxnbskyzzgjzlqjdfcjxdygjqjjpmgwgjjjpkjsbgbmmcjssclpqpdxcdyykypcjddyygywchjrtgcnyql",
    "dkljczzgzccjgdyksgpzmdlcphnjafyzdjcnmwescsglbtzcgmsdllyxqsxsbljsbbsgghfjlwpmzjnlyywdqshzxtyy",
    "whmcyhywdbxbtlmswyyfsbjcbdxxlhjhfpsxzqhfzmqcztqcxzxrdkdjhnnyzqqfnqdmmgnydxmjgdhcdycbffallztd",
    "ltfkmxqzdngeqdbdczjdxbzgsqqddjcmbkxffxmkdmcsychzcmljdjynhprsjmkmpcklgdbqtfzswtfgglyplljzhgjj",
    "gypzltcsmcnbtjbhfkdhbyzgkpbbymtdlsxsbnpdkleycjnycdykzddhqgsdzsctarlltkzlgecllkjljjaqnbdggghf",
    "jtzqjsecshalqfmmgjnlyjbbtmlycxdcjpldlpcqdhsycbzsckbzmsljflhrbjsnbrgjhxpdgdjybzgdlgcsezgxlblg",
    "yxtwmabchecmwyjyzlljjshlgndjlslygkdzpzxjyyzlpcxszfgwyydlyhcljscmbjhblyjlycblydpdqysxktbytdkd",
    "xjypcnrjmfdjgklccjbctbjddbblblcdqrppxjcglzcshltoljnmdddlngkaqakgjgyhheznmshrphqqjchgmfprxcjg",
    "dychghlyrzqlcngjnzsqdkqjymszswlcfqjqxgbggxmdjwlmcrnfkkfsyyljbmqammmycctbshcptxxzzsmphfshmclm",
    "ldjfyqxsdyjdjjzzhqpdszglssjbckbxyqzjsgpsxjzqznqtbdkwxjkhhgflbcsmdldgdzdblzkycqnncsybzbfglzzx",
    "swmsccmqnjqsbdqsjtxxmbldxcclzshzcxrqjgjylxzfjphymzqqydfqjjlcznzjcdgzygcdxmzysctlkphtxhtlbjxj",
    "lxscdqccbbqjfqzfsltjbtkqbsxjjljchczdbzjdczjccprnlqcgpfczlclcxzdmxmphgsgzgszzqjxlwtjpfsyaslcj",
    "btckwcwmytcsjjljcqlwzmalbxyfbpnlschtgjwejjxxglljstgshjqlzfkcgnndszfdeqfhbsaqdgylbxmmygszldyd",
    "jmjjrgbjgkgdhgkblgkbdmbylxwcxyttybkmrjjzxqjbhlmhmjjzmqasldcyxyqdlqcafywyxqhz"
  };

  localparam int ROM_LEN = $bits(ROM_TEXT) / 8;

  // Letter for a code in the first-level block, by range bounds.
  function automatic logic [6:0] range_letter(input logic [13:0] code);
    logic [6:0] l;
    logic       hit;
    l   = 7'd0;
    hit = 1'b0;
    for (int k = 0; k < RANGE_COUNT; k++) begin
      if (!hit && (code < RANGE_TOP[k])) begin
        l   = RANGE_LETTER[k];
        hit = 1'b1;
      end
    end
    return l;
  endfunction

  // Uppercase initial from the letter ROM, 0 past its end or for a non-letter.
  function automatic logic [6:0] rom_letter(input logic [11:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < ROM_LEN) begin
      c = ROM_TEXT[8 * (ROM_LEN - 1 - int'(idx)) +: 8];
    end
    if ((c >= ASCII_LOWER_A) && (c <= ASCII_LOWER_Z)) begin
      return 7'(c - ASCII_CASE);
    end else if ((c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
      return c[6:0];
    end
    return 7'd0;
  endfunction

endpackage

`default_nettype wire

/* hdl/gbpy_if.sv */
// Valid/ready channel interfaces for the byte input and the letter output.
// Self-contained; used by the front end, the back end and the top level.
`default_nettype none

interface gbpy_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface gbpy_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] letter;
  logic       letter_valid;
  logic       end_of_name;

  modport source (output valid, output letter, output letter_valid, output end_of_name,
                  input ready);
  modport sink   (input valid, input letter, input letter_valid, input end_of_name,
                  output ready);
endinterface

`default_nettype wire

/* hdl/gbpy_front.sv */
// Front end: accepts bytes, pairs GB2312 bytes and classifies each character.
// Depends on gbpy_pkg and gbpy_in_if; pushes jobs into gbpy_queue.
`default_nettype none

module gbpy_front
  import gbpy_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  gbpy_in_if.sink    in_ch,
  input  wire logic  queue_full,
  output logic       push,
  output job_t       push_job
);

  logic       pend_v_r,  pend_v_nxt;
  logic [7:0] pend_hi_r, pend_hi_nxt;

  logic        accept;
  logic        pair;
  logic [6:0]  row;
  logic [6:0]  col;
  logic [13:0] code;
  logic [11:0] rom_idx;
  kind_t       kind;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign pair = pend_v_r && (pend_hi_r >= PAIR_MIN) && (in_ch.text_byte >= PAIR_MIN);
  assign row  = 7'(pend_hi_r - PAIR_BIAS);
  assign col  = 7'(in_ch.text_byte - PAIR_BIAS);
  assign code = 14'(14'(row) * ROW_WEIGHT) + 14'(col);
  assign rom_idx = 12'(12'(row - ROM_ROW_BASE) * ROM_ROW_SPAN) + 12'(col) - 12'd1;

  always_comb begin
    kind = KIND_NONE;
    if (pair) begin
      if ((code >= CODE_RANGE_LO) && (code < CODE_RANGE_END)) begin
        kind = KIND_RANGE;
      end else if ((code >= CODE_ROM_LO) && (code <= CODE_ROM_HI)) begin
        kind = KIND_ROM;
      end
    end
  end

  always_comb begin
    pend_v_nxt  = pend_v_r;
    pend_hi_nxt = pend_hi_r;
    if (accept) begin
      if (pair || (in_ch.text_byte < LEAD_MIN) || in_ch.last_byte) begin
        pend_v_nxt  = 1'b0;
        pend_hi_nxt = 8'h00;
      end else begin
        // hold a lead byte until its partner arrives
        pend_v_nxt  = 1'b1;
        pend_hi_nxt = in_ch.text_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r  <= 1'b0;
      pend_hi_r <= 8'h00;
    end else begin
      pend_v_r  <= pend_v_nxt;
      pend_hi_r <= pend_hi_nxt;
    end
  end

  // drop bytes that can produce no result
  assign push = accept && ((kind != KIND_NONE) || in_ch.last_byte);

  always_comb begin
    push_job.kind    = kind;
    push_job.code    = code;
    push_job.rom_idx = rom_idx;
    push_job.last    = in_ch.last_byte;
  end

endmodule

`default_nettype wire

/* hdl/gbpy_queue.sv */
// Short job queue that decouples the front end from the back end.
// Depends on gbpy_pkg for the job type.
`default_nettype none

module gbpy_queue
  import gbpy_pkg::*;
#(
  parameter int DEPTH = GBPY_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output job_t      pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_FULL);
  assign pop_valid = (count_r != '0);
  assign pop_job   = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* hdl/gbpy_back.sv */
// Back end: looks up the initial (range table or letter ROM) and drives results.
// Depends on gbpy_pkg and gbpy_out_if; pops jobs from gbpy_queue.
`default_nettype none

module gbpy_back
  import gbpy_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  job_valid,
  input  wire job_t  job,
  output logic       pop,
  gbpy_out_if.source out_ch
);

  // lookup stage
  logic       lk_v_r,      lk_v_nxt;
  logic [6:0] lk_letter_r, lk_letter_nxt;
  logic       lk_last_r,   lk_last_nxt;

  // output register
  logic       out_v_r,      out_v_nxt;
  logic [6:0] out_letter_r, out_letter_nxt;
  logic       out_lv_r,     out_lv_nxt;
  logic       out_end_r,    out_end_nxt;

  logic emit;
  logic out_free;
  logic lk_free;
  logic load_out;

  assign emit     = (lk_letter_r != 7'd0) || lk_last_r;
  assign out_free = !out_v_r || out_ch.ready;
  // a lookup with nothing to report leaves without waiting on the output
  assign lk_free  = !lk_v_r || !emit || out_free;
  assign load_out = lk_v_r && emit && out_free;
  assign pop      = job_valid && lk_free;

  always_comb begin
    lk_v_nxt      = lk_v_r;
    lk_letter_nxt = lk_letter_r;
    lk_last_nxt   = lk_last_r;
    if (lk_free) begin
      lk_v_nxt = pop;
    end
    if (pop) begin
      lk_last_nxt = job.last;
      unique case (job.kind)
        KIND_RANGE: lk_letter_nxt = range_letter(job.code);
        KIND_ROM:   lk_letter_nxt = rom_letter(job.rom_idx);
        default:    lk_letter_nxt = 7'd0;
      endcase
    end
  end

  always_comb begin
    out_v_nxt      = out_v_r;
    out_letter_nxt = out_letter_r;
    out_lv_nxt     = out_lv_r;
    out_end_nxt    = out_end_r;
    if (load_out) begin
      out_v_nxt      = 1'b1;
      out_letter_nxt = lk_letter_r;
      out_lv_nxt     = (lk_letter_r != 7'd0);
      out_end_nxt    = lk_last_r;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      lk_v_r  <= lk_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lk_letter_r  <= lk_letter_nxt;
    lk_last_r    <= lk_last_nxt;
    out_letter_r <= out_letter_nxt;
    out_lv_r     <= out_lv_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.letter       = out_letter_r;
  assign out_ch.letter_valid = out_lv_r;
  assign out_ch.end_of_name  = out_end_r;

endmodule

`default_nettype wire

/* hdl/gb2312_pinyin_initial_extractor.sv */
// Path: a result reaches out_ch via the job queue, the lookup stage and the output register.
// Throughput: one byte per cycle while the job queue is not full; the front end pairs bytes
// combinationally, the back end reads the range table or the letter ROM into a register.
// Reset (rst_n low, synchronous) drops any pending lead byte, empties the job queue
// and clears the lookup and output stages; no clearing pass is needed.
// Depends on gbpy_pkg, gbpy_if, gbpy_front, gbpy_queue and gbpy_back.
`default_nettype none

module gb2312_pinyin_initial_extractor
  import gbpy_pkg::*;
#(
  parameter int QUEUE_DEPTH = GBPY_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gbpy_in_if.sink    in_ch,
  gbpy_out_if.source out_ch
);

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic pop_valid;
  job_t pop_job;

  gbpy_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  gbpy_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  gbpy_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job       (pop_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

/* hdl/gbpy_checker.sv */
// Port-level checks on the result channel of the pinyin initial extractor.
// Bound to gb2312_pinyin_initial_extractor; sees its ports only.
`default_nettype none

module gbpy_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] letter,
  input wire logic       letter_valid,
  input wire logic       end_of_name
);

  localparam logic [6:0] LETTER_MIN = 7'd65;
  localparam logic [6:0] LETTER_MAX = 7'd90;

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(letter) && $stable(letter_valid)
      && $stable(end_of_name))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> letter_valid || end_of_name)
    else $error("result carries neither a letter nor end of name");

  a_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !letter_valid |-> letter == 7'd0)
    else $error("letter nonzero without letter_valid");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && letter_valid |-> (letter >= LETTER_MIN) && (letter <= LETTER_MAX))
    else $error("letter outside A..Z");

endmodule

bind gb2312_pinyin_initial_extractor gbpy_checker u_gbpy_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .letter       (out_ch.letter),
  .letter_valid (out_ch.letter_valid),
  .end_of_name  (out_ch.end_of_name)
);

`default_nettype wire
